// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the reprojection block.
// No dependencies; take in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DTP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/dtp_pkg.sv -----
// Types and constants for the disparity-to-point reprojection block.
// No dependencies; every module of the block imports it.
package dtp_pkg;

   // Configuration register indexes
   localparam logic [2:0] REG_DEPTH_NUMERATOR  = 3'd0;
   localparam logic [2:0] REG_INVERSE_FOCAL    = 3'd1;
   localparam logic [2:0] REG_CENTER_X_DOUBLED = 3'd2;
   localparam logic [2:0] REG_CENTER_Y_DOUBLED = 3'd3;
   localparam logic [2:0] REG_BORDER           = 3'd4;
   localparam logic [2:0] REG_LEFT_START       = 3'd5;
   localparam logic [2:0] REG_FRAME_WIDTH      = 3'd6;
   localparam logic [2:0] REG_FRAME_HEIGHT     = 3'd7;

   // Accepted disparity window, exclusive bounds
   localparam logic signed [15:0] DISP_LOW  = 16'sd50;
   localparam logic signed [15:0] DISP_HIGH = 16'sd800;

   typedef struct packed {
      logic signed [15:0] disparity;
      logic [11:0]        column;
      logic [11:0]        row;
   } dtp_req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic               valid_res;
   } dtp_rsp_type;

   typedef struct packed {
      logic [31:0] depth_numerator;
      logic [31:0] inverse_focal;
      logic [12:0] center_x_doubled;
      logic [12:0] center_y_doubled;
      logic [7:0]  border;
      logic [11:0] left_start;
      logic [12:0] frame_width;
      logic [12:0] frame_height;
   } dtp_cfg_type;

   // Classified pixel handed from front to back
   typedef struct packed {
      logic               disp_ok;
      logic [9:0]         disp;
      logic signed [13:0] dx;
      logic signed [13:0] dy;
   } dtp_work_type;

   // Queue status seen by the front and the top level
   typedef struct packed {
      logic full;
      logic empty;
   } dtp_queue_stat_type;

endpackage

// ----- hw/rtl/disparity_to_point_reprojection.sv -----
// A pixel passes the queue, the 32-step division pipeline, two multiplier stages and the
// output register. Throughput: one pixel per cycle while the output is not stalled; all
// stages advance together; a 4-entry queue keeps input flowing in output stalls until full.
// Reset: synchronous, active high; clears queue and pipeline valids and loads the register
// defaults. Pixels outside the working region give no result.
`include "assert_macros.svh"

module disparity_to_point_reprojection import dtp_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dtp_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dtp_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   dtp_cfg_type        cfg_ff;
   dtp_queue_stat_type queue_stat;
   logic               push;
   dtp_work_type       push_data;
   logic               head_valid;
   dtp_work_type       head_data;
   logic               pop;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_numerator  <= 32'd52203566;
         cfg_ff.inverse_focal    <= 32'd10737418;
         cfg_ff.center_x_doubled <= 13'd1039;
         cfg_ff.center_y_doubled <= 13'd799;
         cfg_ff.border           <= 8'd8;
         cfg_ff.left_start       <= 12'd120;
         cfg_ff.frame_width      <= 13'd1040;
         cfg_ff.frame_height     <= 13'd800;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DEPTH_NUMERATOR:  cfg_ff.depth_numerator  <= csr_data;
            REG_INVERSE_FOCAL:    cfg_ff.inverse_focal    <= csr_data;
            REG_CENTER_X_DOUBLED: cfg_ff.center_x_doubled <= csr_data[12:0];
            REG_CENTER_Y_DOUBLED: cfg_ff.center_y_doubled <= csr_data[12:0];
            REG_BORDER:           cfg_ff.border           <= csr_data[7:0];
            REG_LEFT_START:       cfg_ff.left_start       <= csr_data[11:0];
            REG_FRAME_WIDTH:      cfg_ff.frame_width      <= csr_data[12:0];
            REG_FRAME_HEIGHT:     cfg_ff.frame_height     <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   dtp_front u_front (
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_stat (queue_stat),
      .push       (push),
      .push_data  (push_data)
   );

   dtp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .stat       (queue_stat)
   );

   dtp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .work_valid (head_valid),
      .work_data  (head_data),
      .work_pop   (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // Checks
   `DTP_ASSERT_NEXT(a_push_fills, clock, reset, push, !queue_stat.empty, "queue empty after push")
   `DTP_ASSERT_IMPLY(a_full_stalls, clock, reset, queue_stat.full, !req_ready, "ready while full")
   `DTP_ASSERT_IMPLY(a_z_positive, clock, reset, rsp_valid && rsp_data.valid_res,
                     !rsp_data.point_z[31], "negative depth on valid point")
   `DTP_ASSERT_IMPLY(a_invalid_zero, clock, reset, rsp_valid && !rsp_data.valid_res,
                     rsp_data.point_x == 32'sd0 && rsp_data.point_y == 32'sd0
                     && rsp_data.point_z == 32'sd0,
                     "invalid point carries coordinates")

endmodule

// ----- hw/rtl/dtp_front.sv -----
// Front end: accepts pixels, drops those outside the working region, classifies the rest.
// Depends on dtp_pkg.
module dtp_front import dtp_pkg::*; (
   input  logic               reset,
   input  dtp_cfg_type        cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  dtp_req_type        req_data,
   input  dtp_queue_stat_type queue_stat,
   output logic               push,
   output dtp_work_type       push_data
);

   logic in_region;
   logic row_low_ok;
   logic row_high_ok;
   logic col_low_ok;
   logic col_high_ok;

   // Stall only on a full queue
   assign req_ready = !queue_stat.full;

   // Region test on row and column
   always_comb begin
      row_low_ok  = {1'b0, req_data.row} >= {5'b0, cfg.border};
      row_high_ok = ({1'b0, req_data.row} + {5'b0, cfg.border}) < cfg.frame_height;
      col_low_ok  = req_data.column >= cfg.left_start;
      col_high_ok = ({1'b0, req_data.column} + {5'b0, cfg.border}) < cfg.frame_width;
      in_region   = row_low_ok && row_high_ok && col_low_ok && col_high_ok;
   end

   // Classify disparity and form centre offsets
   always_comb begin
      push_data.disp_ok = (req_data.disparity > DISP_LOW) && (req_data.disparity < DISP_HIGH);
      push_data.disp    = req_data.disparity[9:0];
      push_data.dx      = $signed({1'b0, req_data.column, 1'b0})
                          - $signed({1'b0, cfg.center_x_doubled});
      push_data.dy      = $signed({1'b0, req_data.row, 1'b0})
                          - $signed({1'b0, cfg.center_y_doubled});
   end

   // Push each in-region transfer
   assign push = req_valid && req_ready && in_region && !reset;

endmodule

// ----- hw/rtl/dtp_queue.sv -----
// Short queue between front and back so each side stalls on its own.
// Depends on dtp_pkg.
module dtp_queue import dtp_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dtp_work_type       push_data,
   input  logic               pop,
   output logic               head_valid,
   output dtp_work_type       head_data,
   output dtp_queue_stat_type stat
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   dtp_work_type        mem_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   assign stat.full  = (count_ff == CntW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_valid = !stat.empty;
   assign head_data  = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/dtp_back.sv -----
// Back end: pipelined depth division, offset scaling, saturation and output register.
// Depends on dtp_pkg.
module dtp_back import dtp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  dtp_cfg_type  cfg,
   input  logic         work_valid,
   input  dtp_work_type work_data,
   output logic         work_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output dtp_rsp_type  rsp_data
);

   localparam int DivSteps = 32;

   typedef struct packed {
      logic               disp_ok;
      logic [9:0]         disp;
      logic signed [13:0] dx;
      logic signed [13:0] dy;
      logic [9:0]         rem;
      logic [31:0]        quo;
   } div_stage_type;

   // One restoring division step
   function automatic div_stage_type div_step(input div_stage_type s, input logic nbit);
      div_stage_type r;
      logic [10:0]   part;
      logic [10:0]   diff;
      r    = s;
      part = {s.rem, nbit};
      diff = part - {1'b0, s.disp};
      if (part >= {1'b0, s.disp}) begin
         r.rem = diff[9:0];
         r.quo = {s.quo[30:0], 1'b1};
      end else begin
         r.rem = part[9:0];
         r.quo = {s.quo[30:0], 1'b0};
      end
      return r;
   endfunction

   // Truncated magnitude back to signed 32 bits with saturation
   function automatic logic [31:0] clip(input logic [39:0] q, input logic neg);
      logic [39:0] nq;
      logic [31:0] r;
      nq = -q;
      if (neg) begin
         r = (q > 40'h0080000000) ? 32'h80000000 : nq[31:0];
      end else begin
         r = (q > 40'h007FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
      end
      return r;
   endfunction

   logic                 advance;
   logic                 rsp_valid_ff;
   dtp_rsp_type          rsp_data_ff, rsp_data_in;
   div_stage_type        div_src [DivSteps];
   div_stage_type        div_ff  [DivSteps];
   logic [DivSteps-1:0]  div_vld_ff;

   logic                 m1_vld_ff;
   logic                 m1_ok_ff;
   logic                 m1_negx_ff, m1_negy_ff;
   logic [26:0]          m1_z_ff;
   logic [39:0]          m1_magx_ff, m1_magy_ff;
   logic [12:0]          absx, absy;
   logic [13:0]          negdx, negdy;
   div_stage_type        div_last;

   logic                 m2_vld_ff;
   logic                 m2_ok_ff;
   logic                 m2_negx_ff, m2_negy_ff;
   logic [26:0]          m2_z_ff;
   logic [55:0]          m2_ax_ff, m2_bx_ff, m2_ay_ff, m2_by_ff;
   logic [56:0]          sum_x, sum_y;

   // Whole pipeline moves together unless the output is held
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign work_pop  = advance && work_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Division stages, one quotient bit each
   for (genvar i = 0; i < DivSteps; i++) begin : g_div
      if (i == 0) begin : g_head
         assign div_src[i] = '{disp_ok: work_data.disp_ok, disp: work_data.disp,
                               dx: work_data.dx, dy: work_data.dy, rem: '0, quo: '0};
      end else begin : g_body
         assign div_src[i] = div_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            div_ff[i] <= div_step(div_src[i], cfg.depth_numerator[DivSteps-1-i]);
         end
      end
   end

   assign div_last = div_ff[DivSteps-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff <= '0;
         m1_vld_ff  <= 1'b0;
         m2_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         div_vld_ff   <= {div_vld_ff[DivSteps-2:0], work_valid};
         m1_vld_ff    <= div_vld_ff[DivSteps-1];
         m2_vld_ff    <= m1_vld_ff;
         rsp_valid_ff <= m2_vld_ff;
      end
   end

   // Offset magnitudes
   always_comb begin
      negdx = -div_last.dx;
      negdy = -div_last.dy;
      absx  = div_last.dx[13] ? negdx[12:0] : div_last.dx[12:0];
      absy  = div_last.dy[13] ? negdy[12:0] : div_last.dy[12:0];
   end

   // Depth times offset
   always_ff @(posedge clock) begin
      if (advance) begin
         m1_ok_ff   <= div_last.disp_ok;
         m1_negx_ff <= div_last.dx[13];
         m1_negy_ff <= div_last.dy[13];
         m1_z_ff    <= div_last.quo[26:0];
         m1_magx_ff <= div_last.quo[26:0] * absx;
         m1_magy_ff <= div_last.quo[26:0] * absy;
      end
   end

   // Partial products with the inverse focal halves
   always_ff @(posedge clock) begin
      if (advance) begin
         m2_ok_ff   <= m1_ok_ff;
         m2_negx_ff <= m1_negx_ff;
         m2_negy_ff <= m1_negy_ff;
         m2_z_ff    <= m1_z_ff;
         m2_ax_ff   <= m1_magx_ff * cfg.inverse_focal[31:16];
         m2_bx_ff   <= m1_magx_ff * cfg.inverse_focal[15:0];
         m2_ay_ff   <= m1_magy_ff * cfg.inverse_focal[31:16];
         m2_by_ff   <= m1_magy_ff * cfg.inverse_focal[15:0];
      end
   end

   // Combine partials, shift, saturate; zero the point when out of range
   always_comb begin
      sum_x = {1'b0, m2_ax_ff} + {17'b0, m2_bx_ff[55:16]};
      sum_y = {1'b0, m2_ay_ff} + {17'b0, m2_by_ff[55:16]};
      rsp_data_in = '0;
      if (m2_ok_ff) begin
         rsp_data_in.point_x   = clip(sum_x[56:17], m2_negx_ff);
         rsp_data_in.point_y   = clip(sum_y[56:17], m2_negy_ff);
         rsp_data_in.point_z   = {5'b0, m2_z_ff};
         rsp_data_in.valid_res = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- sim/disparity_to_point_reprojection_tb.sv -----
// Self-checking testbench for disparity_to_point_reprojection: random and directed pixels
// under several register settings, with a local predictor. Depends on dtp_pkg and the RTL.
`timescale 1ns / 1ps

module disparity_to_point_reprojection_tb;
   import dtp_pkg::*;

   localparam int  CYCLE_LIMIT = 1000000;
   localparam int  SETTLE      = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   dtp_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   dtp_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   dtp_req_type pixel_queue[$];
   dtp_rsp_type point_queue[$];
   dtp_cfg_type cfg_mirror;
   int          error_count = 0;
   int          cycle_count = 0;
   logic        req_took = 1'b0;
   logic        csr_took = 1'b0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_mode = 0;
   int          mode_left = 0;
   int          hold_left = 0;
   logic        long_hold_go = 1'b0;

   disparity_to_point_reprojection i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // Scale an offset product by the inverse focal length, truncate toward zero, saturate
   function automatic logic signed [31:0] scale_lateral(longint t, logic [31:0] inv);
      logic          neg;
      longint unsigned mag, a, b, q;
      neg = t < 0;
      mag = neg ? longint'(-t) : t;
      a = mag * longint'(inv[31:16]);
      b = mag * longint'(inv[15:0]);
      q = (a + (b >> 16)) >> 17;
      if (neg) return (q > 64'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
      return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
   endfunction

   // Reproject one pixel; return 0 when it lies outside the working region
   function automatic bit reproject_pixel(dtp_req_type px, dtp_cfg_type c,
                                          output dtp_rsp_type pt);
      int     d, col, row;
      longint z, dx, dy;
      d = px.disparity;
      col = px.column;
      row = px.row;
      pt = '0;
      if (row < c.border || row + c.border >= c.frame_height) return 0;
      if (col < c.left_start || col + c.border >= c.frame_width) return 0;
      if (d > DISP_LOW && d < DISP_HIGH) begin
         z = longint'(c.depth_numerator) / d;
         dx = 2 * col - longint'(c.center_x_doubled);
         dy = 2 * row - longint'(c.center_y_doubled);
         pt.point_z = z[31:0];
         pt.point_x = scale_lateral(z * dx, c.inverse_focal);
         pt.point_y = scale_lateral(z * dy, c.inverse_focal);
         pt.valid_res = 1'b1;
      end
      return 1;
   endfunction

   // Record transfers, predict on input, check on output
   always @(posedge clock) begin
      dtp_rsp_type pt, want;
      req_took <= req_valid && req_ready && !reset;
      csr_took <= csr_valid && csr_ready && !reset;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("disparity_to_point_reprojection_tb: FAIL");
         $finish;
      end
      if (!reset && req_valid && req_ready)
         if (reproject_pixel(req_data, cfg_mirror, pt)) point_queue.push_back(pt);
      if (!reset && rsp_valid && rsp_ready) begin
         if (point_queue.size() == 0) begin
            $error("unexpected result %h", rsp_data);
            error_count = error_count + 1;
         end else begin
            want = point_queue.pop_front();
            if (rsp_data.point_x !== want.point_x) begin
               $error("point_x expected %h actual %h", want.point_x, rsp_data.point_x);
               error_count = error_count + 1;
            end
            if (rsp_data.point_y !== want.point_y) begin
               $error("point_y expected %h actual %h", want.point_y, rsp_data.point_y);
               error_count = error_count + 1;
            end
            if (rsp_data.point_z !== want.point_z) begin
               $error("point_z expected %h actual %h", want.point_z, rsp_data.point_z);
               error_count = error_count + 1;
            end
            if (rsp_data.valid_res !== want.valid_res) begin
               $error("valid_res expected %b actual %b", want.valid_res, rsp_data.valid_res);
               error_count = error_count + 1;
            end
         end
      end
   end

   // Pixel driver: hold until transfer, then advance in bursts with gaps
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_took)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pixel_queue.size() > 0) begin
            req_data <= pixel_queue.pop_front();
            req_valid <= 1'b1;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: own stall pattern, plus one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold_go && hold_left == 0 && stall_mode >= 0) begin
         hold_left <= 400;
         stall_mode <= -1;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(16, 80);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= ($urandom_range(0, 1) == 1);
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 3) == 0);
            end
         endcase
      end
   end

   // Write one register through the configuration channel and mirror it
   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_took);
      csr_valid <= 1'b0;
      case (idx)
         REG_DEPTH_NUMERATOR:  cfg_mirror.depth_numerator = value;
         REG_INVERSE_FOCAL:    cfg_mirror.inverse_focal = value;
         REG_CENTER_X_DOUBLED: cfg_mirror.center_x_doubled = value[12:0];
         REG_CENTER_Y_DOUBLED: cfg_mirror.center_y_doubled = value[12:0];
         REG_BORDER:           cfg_mirror.border = value[7:0];
         REG_LEFT_START:       cfg_mirror.left_start = value[11:0];
         REG_FRAME_WIDTH:      cfg_mirror.frame_width = value[12:0];
         default:              cfg_mirror.frame_height = value[12:0];
      endcase
   endtask

   task automatic write_all(logic [31:0] num, logic [31:0] inv, logic [12:0] cx,
                            logic [12:0] cy, logic [7:0] brd, logic [11:0] left,
                            logic [12:0] w, logic [12:0] h);
      write_reg(REG_DEPTH_NUMERATOR, num);
      write_reg(REG_INVERSE_FOCAL, inv);
      write_reg(REG_CENTER_X_DOUBLED, {19'd0, cx});
      write_reg(REG_CENTER_Y_DOUBLED, {19'd0, cy});
      write_reg(REG_BORDER, {24'd0, brd});
      write_reg(REG_LEFT_START, {20'd0, left});
      write_reg(REG_FRAME_WIDTH, {19'd0, w});
      write_reg(REG_FRAME_HEIGHT, {19'd0, h});
   endtask

   // Wait until the pipe is empty, then let in-flight regionless pixels clear
   task automatic drain();
      wait (pixel_queue.size() == 0 && !req_valid && point_queue.size() == 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   function automatic dtp_req_type make_pixel(int d, int col, int row);
      dtp_req_type px;
      px.disparity = d[15:0];
      px.column = col[11:0];
      px.row = row[11:0];
      return px;
   endfunction

   // Disparity mix: mostly in range, some edges and raw noise
   function automatic int pick_disparity();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: return $urandom_range(0, 65535) - 32768;
         1: return $urandom_range(0, 3) + ($urandom_range(0, 1) ? 49 : 798);
         default: return $urandom_range(51, 799);
      endcase
   endfunction

   // Mostly pixels inside the region, the rest anywhere
   task automatic push_random(int count);
      int lo_c, hi_c, lo_r, hi_r;
      lo_c = cfg_mirror.left_start;
      hi_c = int'(cfg_mirror.frame_width) - int'(cfg_mirror.border) - 1;
      lo_r = cfg_mirror.border;
      hi_r = int'(cfg_mirror.frame_height) - int'(cfg_mirror.border) - 1;
      if (hi_c > 4095) hi_c = 4095;
      if (hi_r > 4095) hi_r = 4095;
      repeat (count) begin
         if ($urandom_range(0, 4) != 0 && hi_c >= lo_c && hi_r >= lo_r)
            pixel_queue.push_back(make_pixel(pick_disparity(),
               $urandom_range(lo_c, hi_c), $urandom_range(lo_r, hi_r)));
         else
            pixel_queue.push_back(make_pixel(pick_disparity(),
               $urandom_range(0, 4095), $urandom_range(0, 4095)));
      end
   endtask

   initial begin
      cfg_mirror = '{52203566, 10737418, 1039, 799, 8, 120, 1040, 800};
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed: region edges, disparity bounds, sign extremes under reset values
      pixel_queue.push_back(make_pixel(51, 120, 8));
      pixel_queue.push_back(make_pixel(799, 1031, 791));
      pixel_queue.push_back(make_pixel(50, 500, 400));
      pixel_queue.push_back(make_pixel(800, 500, 400));
      pixel_queue.push_back(make_pixel(-32768, 500, 400));
      pixel_queue.push_back(make_pixel(32767, 500, 400));
      pixel_queue.push_back(make_pixel(-1, 500, 400));
      pixel_queue.push_back(make_pixel(0, 500, 400));
      pixel_queue.push_back(make_pixel(100, 119, 400));
      pixel_queue.push_back(make_pixel(100, 1032, 400));
      pixel_queue.push_back(make_pixel(100, 500, 7));
      pixel_queue.push_back(make_pixel(100, 500, 792));
      pixel_queue.push_back(make_pixel(100, 4095, 4095));
      pixel_queue.push_back(make_pixel(100, 0, 0));
      pixel_queue.push_back(make_pixel(300, 519, 399));
      pixel_queue.push_back(make_pixel(300, 520, 400));
      drain();
      push_random(150);
      drain();

      // Saturating lateral values, zero horizontal centre, maximal vertical centre, whole frame open
      write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd0, 13'd8191, 8'd0, 12'd0,
                13'd4096, 13'd4096);
      pixel_queue.push_back(make_pixel(51, 4095, 0));
      pixel_queue.push_back(make_pixel(51, 0, 4095));
      pixel_queue.push_back(make_pixel(799, 4095, 4095));
      push_random(120);
      drain();

      // Zero numerator and unit scale still mark points valid
      write_all(32'd0, 32'd1, 13'd4095, 13'd4095, 8'd255, 12'd4095, 13'd4096, 13'd4096);
      pixel_queue.push_back(make_pixel(200, 4095, 300));
      drain();
      write_reg(REG_LEFT_START, 32'd300);
      pixel_queue.push_back(make_pixel(200, 1000, 1000));
      push_random(60);
      drain();

      // Degenerate frame: a region of the single pixel at column 0, row 0
      write_all(32'h0123_4567, 32'h0000_FFFF, 13'd1, 13'd1, 8'd0, 12'd0, 13'd1, 13'd1);
      pixel_queue.push_back(make_pixel(100, 0, 0));
      push_random(30);
      drain();

      // Long receiver hold-off while pixels keep coming
      write_all(32'h0400_0000, 32'h00A0_0000, 13'd640, 13'd480, 8'd4, 12'd16,
                13'd640, 13'd480);
      long_hold_go = 1'b1;
      push_random(200);
      repeat (8) @(negedge clock);
      long_hold_go = 1'b0;
      drain();

      // Back to the reset values with a rounding-heavy focal scale
      write_all(52203566, 32'h7FFF_FFFF, 1039, 799, 8, 120, 1040, 800);
      push_random(150);
      drain();

      if (error_count == 0) begin
         $display("disparity_to_point_reprojection_tb: PASS");
      end else begin
         $display("disparity_to_point_reprojection_tb: FAIL");
      end
      $finish;
   end

endmodule
